// File: rtl/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types, constants and helpers for the space vector PWM duty pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package svpwm_pkg;

  // Field widths
  localparam int unsigned REF_W  = 16;  // signed Q2.14 reference
  localparam int unsigned DUTY_W = 16;  // unsigned Q1.15 duty
  localparam int unsigned PROD_W = 34;  // product width, holds 3*a^2 and b*2/sqrt3
  localparam int unsigned P_W    = 16;  // b/sqrt3 after rounding
  localparam int unsigned T_W    = 18;  // active-vector times
  localparam int unsigned ACC_W  = 21;  // raw duties before saturation

  // Q16 constants for 1/sqrt3 and 2/sqrt3, carried as positive signed values
  localparam logic signed [PROD_W-1:0] INV_SQRT3_Q16     = 34'sd37837;
  localparam logic signed [PROD_W-1:0] TWO_INV_SQRT3_Q16 = 34'sd75674;
  localparam logic signed [PROD_W-1:0] ROUND_Q16         = 34'sd32768;

  localparam logic signed [ACC_W-1:0] ONE_Q14  = 21'sd16384;
  localparam logic signed [ACC_W-1:0] FULL_Q15 = 21'sd32768;
  localparam logic [DUTY_W-1:0]       DUTY_FULL = 16'd32768;
  localparam logic [DUTY_W-1:0]       DUTY_HALF = 16'd16384;

  typedef enum logic [2:0] {
    SECTOR_1 = 3'd0,
    SECTOR_2 = 3'd1,
    SECTOR_3 = 3'd2,
    SECTOR_4 = 3'd3,
    SECTOR_5 = 3'd4,
    SECTOR_6 = 3'd5
  } sector_t;

  typedef enum logic [1:0] {
    PHASE_A = 2'd0,
    PHASE_B = 2'd1,
    PHASE_C = 2'd2
  } phase_t;

  // Stage 1 result: products and rounded constant multiplies
  typedef struct packed {
    logic                     mod_en;
    logic                     b_neg;
    logic signed [REF_W-1:0]  a;
    logic signed [P_W-1:0]    p;
    logic signed [T_W-1:0]    q;
    logic signed [PROD_W-1:0] bb;
    logic signed [PROD_W-1:0] aa3;
  } prod_t;

  // Stage 2 result: sector and active-vector times
  typedef struct packed {
    logic                  mod_en;
    sector_t               sector;
    logic signed [T_W-1:0] t1;
    logic signed [T_W-1:0] t2;
  } times_t;

  // Stage 3 result: raw low/mid/high duties
  typedef struct packed {
    logic                    mod_en;
    sector_t                 sector;
    logic signed [ACC_W-1:0] d_lo;
    logic signed [ACC_W-1:0] d_mid;
    logic signed [ACC_W-1:0] d_hi;
  } raw_duty_t;

  // Phase that carries the lowest duty in each sector
  function automatic phase_t sector_low(input sector_t s);
    phase_t ph;
    case (s)
      SECTOR_1: ph = PHASE_A;
      SECTOR_2: ph = PHASE_B;
      SECTOR_3: ph = PHASE_B;
      SECTOR_4: ph = PHASE_C;
      SECTOR_5: ph = PHASE_C;
      default:  ph = PHASE_A;
    endcase
    return ph;
  endfunction

  // Phase that carries the middle duty in each sector
  function automatic phase_t sector_mid(input sector_t s);
    phase_t ph;
    case (s)
      SECTOR_1: ph = PHASE_B;
      SECTOR_2: ph = PHASE_A;
      SECTOR_3: ph = PHASE_C;
      SECTOR_4: ph = PHASE_B;
      SECTOR_5: ph = PHASE_A;
      default:  ph = PHASE_C;
    endcase
    return ph;
  endfunction

  // Saturate a raw duty to 0..full period
  function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [ACC_W-1:0] d);
    logic [DUTY_W-1:0] r;
    if (d < 0) begin
      r = '0;
    end else if (d > FULL_Q15) begin
      r = DUTY_FULL;
    end else begin
      r = d[DUTY_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/svpwm_mult.sv
// ----------------------------------------------------------------------------
// svpwm_mult
// Stage 1: constant multiplies b/sqrt3, 2b/sqrt3 with rounding, b^2 and 3a^2.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_mult (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    en,
  input  wire                                    vld_in,
  input  wire                                    mod_en,
  input  wire  signed [svpwm_pkg::REF_W-1:0]     a_in,
  input  wire  signed [svpwm_pkg::REF_W-1:0]     b_in,
  output logic                                   vld,
  output svpwm_pkg::prod_t                       prod
);

  logic signed [svpwm_pkg::PROD_W-1:0] p_prod;
  logic signed [svpwm_pkg::PROD_W-1:0] q_prod;
  logic signed [svpwm_pkg::T_W-1:0]    a3;
  svpwm_pkg::prod_t                    prod_next;

  // Rounded products: floor((b*k + 0.5) / 2^16) by arithmetic bit select
  assign p_prod = svpwm_pkg::PROD_W'(b_in) * svpwm_pkg::INV_SQRT3_Q16
                  + svpwm_pkg::ROUND_Q16;
  assign q_prod = svpwm_pkg::PROD_W'(b_in) * svpwm_pkg::TWO_INV_SQRT3_Q16
                  + svpwm_pkg::ROUND_Q16;
  assign a3     = svpwm_pkg::T_W'(a_in) + (svpwm_pkg::T_W'(a_in) <<< 1);

  always_comb begin
    prod_next.mod_en = mod_en;
    prod_next.b_neg  = b_in[svpwm_pkg::REF_W-1];
    prod_next.a      = a_in;
    prod_next.p      = p_prod[16 +: svpwm_pkg::P_W];
    prod_next.q      = q_prod[16 +: svpwm_pkg::T_W];
    prod_next.bb     = svpwm_pkg::PROD_W'(b_in) * svpwm_pkg::PROD_W'(b_in);
    prod_next.aa3    = svpwm_pkg::PROD_W'(a_in) * svpwm_pkg::PROD_W'(a3);
  end

  // Valid clears on reset; payload does not
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/svpwm_sector.sv
// ----------------------------------------------------------------------------
// svpwm_sector
// Stage 2: sector from signs and b^2 vs 3a^2, then the two active times.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_sector (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     en,
  input  wire                     vld_in,
  input  svpwm_pkg::prod_t        prod,
  output logic                    vld,
  output svpwm_pkg::times_t       times
);

  logic                             le;
  logic                             ge;
  logic                             a_neg;
  logic signed [svpwm_pkg::T_W-1:0] a18;
  logic signed [svpwm_pkg::T_W-1:0] p18;
  svpwm_pkg::sector_t               sector;
  svpwm_pkg::times_t                times_next;

  assign le    = prod.bb <= prod.aa3;
  assign ge    = prod.bb >= prod.aa3;
  assign a_neg = prod.a[svpwm_pkg::REF_W-1];
  assign a18   = svpwm_pkg::T_W'(prod.a);
  assign p18   = svpwm_pkg::T_W'(prod.p);

  // Sector pick, ties go to the lower sector
  always_comb begin
    if (!prod.b_neg) begin
      if (!a_neg && le) begin
        sector = svpwm_pkg::SECTOR_1;
      end else if (ge) begin
        sector = svpwm_pkg::SECTOR_2;
      end else begin
        sector = svpwm_pkg::SECTOR_3;
      end
    end else begin
      if (a_neg && le) begin
        sector = svpwm_pkg::SECTOR_4;
      end else if (ge) begin
        sector = svpwm_pkg::SECTOR_5;
      end else begin
        sector = svpwm_pkg::SECTOR_6;
      end
    end
  end

  // Active-vector times per sector
  always_comb begin
    times_next.mod_en = prod.mod_en;
    times_next.sector = sector;
    case (sector)
      svpwm_pkg::SECTOR_1: begin
        times_next.t1 = a18 - p18;
        times_next.t2 = prod.q;
      end
      svpwm_pkg::SECTOR_2: begin
        times_next.t1 = p18 - a18;
        times_next.t2 = a18 + p18;
      end
      svpwm_pkg::SECTOR_3: begin
        times_next.t1 = prod.q;
        times_next.t2 = -p18 - a18;
      end
      svpwm_pkg::SECTOR_4: begin
        times_next.t1 = -prod.q;
        times_next.t2 = p18 - a18;
      end
      svpwm_pkg::SECTOR_5: begin
        times_next.t1 = -a18 - p18;
        times_next.t2 = a18 - p18;
      end
      default: begin
        times_next.t1 = a18 + p18;
        times_next.t2 = -prod.q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      times <= times_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/svpwm_time.sv
// ----------------------------------------------------------------------------
// svpwm_time
// Stage 3: low/mid/high duties from the active times, overmodulation fallback.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_time (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     en,
  input  wire                     vld_in,
  input  svpwm_pkg::times_t       times,
  output logic                    vld,
  output svpwm_pkg::raw_duty_t    raw
);

  logic signed [svpwm_pkg::ACC_W-1:0] t1w;
  logic signed [svpwm_pkg::ACC_W-1:0] t2w;
  logic signed [svpwm_pkg::ACC_W-1:0] t0;
  svpwm_pkg::raw_duty_t               raw_next;

  assign t1w = svpwm_pkg::ACC_W'(times.t1);
  assign t2w = svpwm_pkg::ACC_W'(times.t2);

  // low = t0, mid = t0 + 2*t1, high = mid + 2*t2, each formed directly
  assign t0 = svpwm_pkg::ONE_Q14 - t1w - t2w;

  always_comb begin
    raw_next.mod_en = times.mod_en;
    raw_next.sector = times.sector;
    if (t0 < 0) begin
      // overmodulation: pin low and high, mid from the second time
      raw_next.d_lo  = '0;
      raw_next.d_mid = svpwm_pkg::FULL_Q15 - (t2w <<< 1);
      raw_next.d_hi  = svpwm_pkg::FULL_Q15;
    end else begin
      raw_next.d_lo  = t0;
      raw_next.d_mid = svpwm_pkg::ONE_Q14 + t1w - t2w;
      raw_next.d_hi  = svpwm_pkg::ONE_Q14 + t1w + t2w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw <= raw_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/svpwm_route.sv
// ----------------------------------------------------------------------------
// svpwm_route
// Stage 4: saturate, steer low/mid/high onto phases A/B/C, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_route (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                en,
  input  wire                                vld_in,
  input  svpwm_pkg::raw_duty_t               raw,
  output logic                               vld,
  output logic [svpwm_pkg::DUTY_W-1:0]       duty_a,
  output logic [svpwm_pkg::DUTY_W-1:0]       duty_b,
  output logic [svpwm_pkg::DUTY_W-1:0]       duty_c
);

  logic [svpwm_pkg::DUTY_W-1:0] c_lo;
  logic [svpwm_pkg::DUTY_W-1:0] c_mid;
  logic [svpwm_pkg::DUTY_W-1:0] c_hi;
  svpwm_pkg::phase_t            ph_lo;
  svpwm_pkg::phase_t            ph_mid;
  logic [svpwm_pkg::DUTY_W-1:0] duty_a_next;
  logic [svpwm_pkg::DUTY_W-1:0] duty_b_next;
  logic [svpwm_pkg::DUTY_W-1:0] duty_c_next;

  assign c_lo   = svpwm_pkg::clamp_duty(raw.d_lo);
  assign c_mid  = svpwm_pkg::clamp_duty(raw.d_mid);
  assign c_hi   = svpwm_pkg::clamp_duty(raw.d_hi);
  assign ph_lo  = svpwm_pkg::sector_low(raw.sector);
  assign ph_mid = svpwm_pkg::sector_mid(raw.sector);

  // Phase steering; disabled gives half duty everywhere
  always_comb begin
    if (!raw.mod_en) begin
      duty_a_next = svpwm_pkg::DUTY_HALF;
      duty_b_next = svpwm_pkg::DUTY_HALF;
      duty_c_next = svpwm_pkg::DUTY_HALF;
    end else begin
      duty_a_next = (ph_lo == svpwm_pkg::PHASE_A) ? c_lo :
                    (ph_mid == svpwm_pkg::PHASE_A) ? c_mid : c_hi;
      duty_b_next = (ph_lo == svpwm_pkg::PHASE_B) ? c_lo :
                    (ph_mid == svpwm_pkg::PHASE_B) ? c_mid : c_hi;
      duty_c_next = (ph_lo == svpwm_pkg::PHASE_C) ? c_lo :
                    (ph_mid == svpwm_pkg::PHASE_C) ? c_mid : c_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      duty_a <= duty_a_next;
      duty_b <= duty_b_next;
      duty_c <= duty_c_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/space_vector_pwm_duty.sv
// Throughput: one transaction per cycle while out_stall is low; four register
// stages (multiply, sector, times, route) each hold one item and advance whenever
// downstream has room, so empty stages are filled even while the output is stalled.
// Reset (rst, synchronous): clears all stage valids and modulation_enable.
// ----------------------------------------------------------------------------
// space_vector_pwm_duty
// Six-sector space vector PWM: alpha/beta reference in, three phase duties out.
// ----------------------------------------------------------------------------
`default_nettype none

module space_vector_pwm_duty (
  input  wire                                  clk,
  input  wire                                  rst,
  // configuration
  input  wire                                  cfg_we,
  input  wire                                  cfg_wdata,
  // reference input
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  signed [svpwm_pkg::REF_W-1:0]   v_alpha,
  input  wire  signed [svpwm_pkg::REF_W-1:0]   v_beta,
  // duty output
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [svpwm_pkg::DUTY_W-1:0]         duty_a,
  output logic [svpwm_pkg::DUTY_W-1:0]         duty_b,
  output logic [svpwm_pkg::DUTY_W-1:0]         duty_c
);

  logic                 modulation_enable;
  logic                 en1, en2, en3, en4;
  logic                 vld1, vld2, vld3;
  svpwm_pkg::prod_t     prod;
  svpwm_pkg::times_t    times;
  svpwm_pkg::raw_duty_t raw;

  // Enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulation_enable <= 1'b0;
    end else if (cfg_we) begin
      modulation_enable <= cfg_wdata;
    end
  end

  // Stage advance: a stage loads when it is empty or the next one moves
  assign en4      = !out_valid || !out_stall;
  assign en3      = !vld3 || en4;
  assign en2      = !vld2 || en3;
  assign en1      = !vld1 || en2;
  assign in_stall = !en1;

  svpwm_mult u_mult (
    .clk    (clk),
    .rst    (rst),
    .en     (en1),
    .vld_in (in_valid),
    .mod_en (modulation_enable),
    .a_in   (v_alpha),
    .b_in   (v_beta),
    .vld    (vld1),
    .prod   (prod)
  );

  svpwm_sector u_sector (
    .clk    (clk),
    .rst    (rst),
    .en     (en2),
    .vld_in (vld1),
    .prod   (prod),
    .vld    (vld2),
    .times  (times)
  );

  svpwm_time u_time (
    .clk    (clk),
    .rst    (rst),
    .en     (en3),
    .vld_in (vld2),
    .times  (times),
    .vld    (vld3),
    .raw    (raw)
  );

  svpwm_route u_route (
    .clk    (clk),
    .rst    (rst),
    .en     (en4),
    .vld_in (vld3),
    .raw    (raw),
    .vld    (out_valid),
    .duty_a (duty_a),
    .duty_b (duty_b),
    .duty_c (duty_c)
  );

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for space_vector_pwm_duty: alpha/beta reference pairs
// go in with random idle gaps, duty transactions come out under random stall,
// and every transaction is compared with an in-bench model of the six-sector
// modulator.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam longint INV_SQRT3     = 37837;   // 1/sqrt3 in Q16
  localparam longint TWO_INV_SQRT3 = 75674;   // 2/sqrt3 in Q16
  localparam longint ROUND_HALF    = 32768;
  localparam longint UNIT_Q14      = 16384;
  localparam longint PERIOD_Q15    = 32768;
  localparam logic [svpwm_pkg::DUTY_W-1:0] DUTY_MID = 16'd16384;
  localparam int LATENCY    = 4;
  localparam int MAX_CYCLES = 200000;

  typedef struct {
    logic signed [svpwm_pkg::REF_W-1:0] va;
    logic signed [svpwm_pkg::REF_W-1:0] vb;
    logic [svpwm_pkg::DUTY_W-1:0]       da;
    logic [svpwm_pkg::DUTY_W-1:0]       db;
    logic [svpwm_pkg::DUTY_W-1:0]       dc;
  } duty_rec_t;

  // Duty predictor and store of expected duty transactions
  class duty_scoreboard;
    bit        mod_en;
    int        errors;
    duty_rec_t expected_q[$];

    function new();
      mod_en = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [svpwm_pkg::DUTY_W-1:0] sat_duty(longint d);
      if (d < 0) return '0;
      if (d > PERIOD_Q15) return svpwm_pkg::DUTY_W'(PERIOD_Q15);
      return svpwm_pkg::DUTY_W'(d);
    endfunction

    // Work out the duties for one accepted reference pair
    function void note_reference(logic signed [svpwm_pkg::REF_W-1:0] va,
                                 logic signed [svpwm_pkg::REF_W-1:0] vb);
      longint             a, b, p, q, t1, t2, t0, bb, aa3;
      longint             d[3];
      svpwm_pkg::sector_t s;
      svpwm_pkg::phase_t  ph_lo, ph_mid, ph_hi;
      duty_rec_t          r;
      r.va = va;
      r.vb = vb;
      if (!mod_en) begin
        r.da = DUTY_MID;
        r.db = DUTY_MID;
        r.dc = DUTY_MID;
        expected_q.push_back(r);
        return;
      end
      a = va;
      b = vb;
      // floor((x*k + half) / 2^16), so halves round up
      p = (b * INV_SQRT3 + ROUND_HALF) >>> 16;
      q = (b * TWO_INV_SQRT3 + ROUND_HALF) >>> 16;
      bb = b * b;
      aa3 = 3 * a * a;
      // sector by sign and slope; ties go to the lower sector
      if (b >= 0) begin
        if (a >= 0 && bb <= aa3) s = svpwm_pkg::SECTOR_1;
        else if (bb >= aa3)      s = svpwm_pkg::SECTOR_2;
        else                     s = svpwm_pkg::SECTOR_3;
      end else begin
        if (a < 0 && bb <= aa3)  s = svpwm_pkg::SECTOR_4;
        else if (bb >= aa3)      s = svpwm_pkg::SECTOR_5;
        else                     s = svpwm_pkg::SECTOR_6;
      end
      case (s)
        svpwm_pkg::SECTOR_1: begin
          t1 = a - p;  t2 = q;
          ph_lo = svpwm_pkg::PHASE_A; ph_mid = svpwm_pkg::PHASE_B; ph_hi = svpwm_pkg::PHASE_C;
        end
        svpwm_pkg::SECTOR_2: begin
          t1 = p - a;  t2 = a + p;
          ph_lo = svpwm_pkg::PHASE_B; ph_mid = svpwm_pkg::PHASE_A; ph_hi = svpwm_pkg::PHASE_C;
        end
        svpwm_pkg::SECTOR_3: begin
          t1 = q;      t2 = -p - a;
          ph_lo = svpwm_pkg::PHASE_B; ph_mid = svpwm_pkg::PHASE_C; ph_hi = svpwm_pkg::PHASE_A;
        end
        svpwm_pkg::SECTOR_4: begin
          t1 = -q;     t2 = p - a;
          ph_lo = svpwm_pkg::PHASE_C; ph_mid = svpwm_pkg::PHASE_B; ph_hi = svpwm_pkg::PHASE_A;
        end
        svpwm_pkg::SECTOR_5: begin
          t1 = -a - p; t2 = a - p;
          ph_lo = svpwm_pkg::PHASE_C; ph_mid = svpwm_pkg::PHASE_A; ph_hi = svpwm_pkg::PHASE_B;
        end
        default: begin
          t1 = a + p;  t2 = -q;
          ph_lo = svpwm_pkg::PHASE_A; ph_mid = svpwm_pkg::PHASE_C; ph_hi = svpwm_pkg::PHASE_B;
        end
      endcase
      t0 = UNIT_Q14 - t1 - t2;
      if (t0 < 0) begin
        // overmodulation: clip to the hexagon edge
        d[ph_lo]  = 0;
        d[ph_mid] = 2 * (UNIT_Q14 - t2);
        d[ph_hi]  = PERIOD_Q15;
      end else begin
        d[ph_lo]  = t0;
        d[ph_mid] = t0 + 2 * t1;
        d[ph_hi]  = t0 + 2 * t1 + 2 * t2;
      end
      r.da = sat_duty(d[svpwm_pkg::PHASE_A]);
      r.db = sat_duty(d[svpwm_pkg::PHASE_B]);
      r.dc = sat_duty(d[svpwm_pkg::PHASE_C]);
      expected_q.push_back(r);
    endfunction

    // Compare one duty transaction with the oldest expectation
    function void check_duties(logic [svpwm_pkg::DUTY_W-1:0] da,
                               logic [svpwm_pkg::DUTY_W-1:0] db,
                               logic [svpwm_pkg::DUTY_W-1:0] dc);
      duty_rec_t r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected duty transaction: %0d %0d %0d", da, db, dc);
        return;
      end
      r = expected_q.pop_front();
      if (da !== r.da || db !== r.db || dc !== r.dc) begin
        errors++;
        if (errors <= 10)
          $display("duty error alpha %0d beta %0d en %0b: expected %0d %0d %0d got %0d %0d %0d",
                   r.va, r.vb, mod_en, r.da, r.db, r.dc, da, db, dc);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [svpwm_pkg::REF_W-1:0] v_alpha = '0;
  logic signed [svpwm_pkg::REF_W-1:0] v_beta = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [svpwm_pkg::DUTY_W-1:0] duty_a, duty_b, duty_c;

  int gap_max = 3;   // upper bound of idle cycles per transaction, both sides
  int cycles = 0;
  duty_scoreboard sb = new();

  space_vector_pwm_duty DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .v_alpha   (v_alpha),
    .v_beta    (v_beta),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .duty_a    (duty_a),
    .duty_b    (duty_b),
    .duty_c    (duty_c)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("space_vector_pwm_duty: mismatch");
      $finish;
    end
  end

  // Check every accepted duty transaction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_duties(duty_a, duty_b, duty_c);
  end

  // Output side: random stall before each transaction
  initial begin
    int n;
    forever begin
      n = $urandom_range(0, gap_max);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Present one reference pair and hold it until accepted
  task automatic send_ref(logic signed [svpwm_pkg::REF_W-1:0] a,
                          logic signed [svpwm_pkg::REF_W-1:0] b);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    v_alpha  <= a;
    v_beta   <= b;
    do @(posedge clk); while (in_stall);
    sb.note_reference(a, b);
  endtask

  // Write the enable once the pipeline has drained
  task automatic write_mode(bit en);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    sb.mod_en = en;
    cfg_we    <= 1'b0;
  endtask

  // Random references, weighted toward the linear region and sector edges
  task automatic send_random(int count);
    logic signed [svpwm_pkg::REF_W-1:0] a, b;
    longint mag;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          a = svpwm_pkg::REF_W'(int'($urandom_range(0, 38000)) - 19000);
          b = svpwm_pkg::REF_W'(int'($urandom_range(0, 38000)) - 19000);
        end
        6, 7: begin
          a = svpwm_pkg::REF_W'($urandom);
          b = svpwm_pkg::REF_W'($urandom);
        end
        8: begin
          // near a 60 degree sector boundary
          mag = $urandom_range(0, 20000);
          b = svpwm_pkg::REF_W'($urandom_range(0, 1) ? mag : -mag);
          mag = ((mag * INV_SQRT3) >>> 16) + int'($urandom_range(0, 2)) - 1;
          a = svpwm_pkg::REF_W'($urandom_range(0, 1) ? mag : -mag);
        end
        default: begin
          // axes and tiny vectors
          a = svpwm_pkg::REF_W'(int'($urandom_range(0, 8)) - 4);
          b = svpwm_pkg::REF_W'(int'($urandom_range(0, 8)) - 4);
          if ($urandom_range(0, 1)) a = $urandom_range(0, 1) ? svpwm_pkg::REF_W'($urandom) : '0;
          else                      b = $urandom_range(0, 1) ? svpwm_pkg::REF_W'($urandom) : '0;
        end
      endcase
      send_ref(a, b);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled after reset: all duties half period
    send_ref(16'sd0, 16'sd0);
    send_ref(16'sd32767, -16'sd32768);
    send_ref(-16'sd12000, 16'sd9000);

    write_mode(1'b1);
    // directed: zero, extremes, negative axis, sector edges, overmodulation
    send_ref(16'sd0, 16'sd0);
    send_ref(16'sd32767, 16'sd0);
    send_ref(-16'sd32768, 16'sd0);
    send_ref(16'sd0, 16'sd32767);
    send_ref(16'sd0, -16'sd32768);
    send_ref(16'sd32767, 16'sd32767);
    send_ref(-16'sd32768, -16'sd32768);
    send_ref(16'sd32767, -16'sd32768);
    send_ref(-16'sd32768, 16'sd32767);
    send_ref(-16'sd1, 16'sd0);
    send_ref(16'sd1, 16'sd1);
    send_ref(-16'sd1, -16'sd1);
    send_ref(16'sd0, -16'sd1);
    send_ref(16'sd9459, 16'sd16384);
    send_ref(-16'sd9459, 16'sd16384);
    send_ref(-16'sd9459, -16'sd16384);
    send_ref(16'sd9459, -16'sd16384);
    send_ref(16'sd16384, 16'sd0);
    send_ref(16'sd20000, 16'sd0);
    send_ref(-16'sd10000, -16'sd17000);

    send_random(600);
    // back-to-back stretch with no idling on either side
    gap_max = 0;
    send_random(200);
    gap_max = 3;
    send_random(100);

    write_mode(1'b0);
    send_random(100);

    write_mode(1'b1);
    send_random(200);

    // drain
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.errors == 0)
      $display("space_vector_pwm_duty: match");
    else
      $display("space_vector_pwm_duty: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
